>>> design/teq_pkg.sv
package teq_pkg;

  // command codes
  localparam logic [1:0] CMD_SCHEDULE = 2'd0;
  localparam logic [1:0] CMD_CANCEL   = 2'd1;
  localparam logic [1:0] CMD_TICK     = 2'd2;

  // result status codes
  localparam logic [2:0] ST_SCHEDULED = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_CANCELLED = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FIRED     = 3'd4;
  localparam logic [2:0] ST_IDLE      = 3'd5;

  // most events fired by one tick
  localparam logic [4:0] MAX_FIRE = 5'd16;

  // one stored event
  typedef struct packed {
    logic [31:0] deadline;
    logic [31:0] id;
    logic [15:0] handle;
    logic        cancelled;
  } entry_t;

  // one result item
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] ev_id;
    logic [15:0] fired_handle;
    logic        last;
  } result_t;

  // true when deadline a lies strictly after deadline b
  function automatic logic later(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return (d != 32'd0) && !d[31];
  endfunction

endpackage

>>> design/teq_cmd_if.sv
interface teq_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [19:0] interval;
  logic [15:0] handle;
  logic [31:0] target_id;

  modport source (output valid, command, interval, handle, target_id, input ready);
  modport sink   (input valid, command, interval, handle, target_id, output ready);
endinterface

>>> design/teq_res_if.sv
interface teq_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] ev_id;
  logic [15:0] fired_handle;
  logic        last;

  modport source (output valid, status, ev_id, fired_handle, last, input ready);
  modport sink   (input valid, status, ev_id, fired_handle, last, output ready);
endinterface

>>> design/teq_ram.sv
module teq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/timer_event_queue.sv
// Sorted timer event queue.
// cmd channel (valid/ready) takes one command item: schedule, cancel or tick.
// rsp channel (valid/ready) returns the result items of that command, the
// final one flagged by last. cfg_we/cfg_wdata write the capacity register
// (0 acts as 1, above QUEUE_DEPTH acts as QUEUE_DEPTH); the user must write it
// only while the block is idle, and the block itself does not enforce this.
// Entries live in one single-port-read RAM; a schedule, cancel or tick with
// entries to visit walks it one entry at a time, an address state and then a
// check/write state for each. Schedule compares entries from the tail,
// shifting later ones up for the sorted insert, until one that is not later
// or the head stops the walk; a full queue answers ST_FULL without a walk.
// Cancel searches from the head. A new command is taken only after the
// previous one's last result has been loaded into the output register.
// A stalled receiver holds the output register; a tick that has further
// events to fire waits on it, other work stops before loading the next result.
// Synchronous reset empties the queue and clears time and id counters; the
// RAM needs no clearing since only entries below the count are read.
module timer_event_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst,
  teq_cmd_if.sink      cmd,
  teq_res_if.source    rsp,
  input  logic         cfg_we,
  input  logic [4:0]   cfg_wdata
);
  import teq_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [6:0] DEPTH7 = 7'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DEPTHC = CW'(QUEUE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_SRD, S_SCHK, S_SINS, S_CRD, S_CCHK, S_TRD, S_TCHK, S_TEND, S_EMIT
  } state_t;

  state_t          state;
  logic [AW-1:0]   rd_addr;
  logic [CW-1:0]   pos;
  logic [CW-1:0]   r;
  logic [CW-1:0]   w;
  logic [4:0]      n;
  logic            sweep;
  logic [CW-1:0]   count;
  logic [31:0]     next_id;
  logic [31:0]     cur_time;
  logic [4:0]      capacity;
  logic [31:0]     new_dl;
  logic [15:0]     new_handle;
  logic [31:0]     target;
  result_t         rslt;
  result_t         pend;
  logic            pend_valid;
  result_t         out;
  logic            out_valid;

  entry_t          rdata;
  entry_t          wdata;
  logic            ram_we;
  logic [AW-1:0]   waddr;

  logic [CW-1:0]   cnt_dec, pos_dec, pos_dec2, r_inc;
  logic [6:0]      cap7, cap_eff;
  logic            full;
  logic            can_push;
  logic            skip_c, fire, copy;
  logic            out_load;

  teq_ram #(.WIDTH($bits(entry_t)), .DEPTH(QUEUE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // helpers
  always_comb begin
    cnt_dec  = count - 1'b1;
    pos_dec  = pos - 1'b1;
    pos_dec2 = pos - CW'(2);
    r_inc    = r + 1'b1;
    cap7     = {2'b00, capacity};
    if (cap7 == 7'd0) begin
      cap_eff = 7'd1;
    end else if (cap7 > DEPTH7) begin
      cap_eff = DEPTH7;
    end else begin
      cap_eff = cap7;
    end
    full     = (7'(count) >= cap_eff) || (count == DEPTHC);
    can_push = !out_valid || rsp.ready;
    skip_c   = sweep && rdata.cancelled;
    fire     = sweep && !rdata.cancelled && !later(rdata.deadline, cur_time) &&
               (n < MAX_FIRE);
    copy     = !skip_c && !fire;
    // output register takes a new item this cycle
    out_load = can_push && (((state == S_TCHK) && fire && pend_valid) ||
                            (state == S_EMIT));
  end

  // RAM write side
  always_comb begin
    ram_we = 1'b0;
    waddr  = pos[AW-1:0];
    wdata  = rdata;
    unique case (state)
      S_SCHK: begin
        if (later(rdata.deadline, new_dl)) begin
          ram_we = 1'b1;
        end
      end
      S_SINS: begin
        ram_we = 1'b1;
        wdata  = '{deadline: new_dl, id: next_id, handle: new_handle, cancelled: 1'b0};
      end
      S_CCHK: begin
        waddr           = r[AW-1:0];
        wdata.cancelled = 1'b1;
        ram_we          = (rdata.id == target);
      end
      S_TCHK: begin
        waddr  = w[AW-1:0];
        ram_we = copy && (w != r);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign cmd.ready        = (state == S_IDLE);
  assign rsp.valid        = out_valid;
  assign rsp.status       = out.status;
  assign rsp.ev_id        = out.ev_id;
  assign rsp.fired_handle = out.fired_handle;
  assign rsp.last         = out.last;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      next_id    <= '0;
      cur_time   <= '0;
      capacity   <= 5'd16;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            new_dl     <= cur_time + {12'd0, cmd.interval};
            new_handle <= cmd.handle;
            target     <= cmd.target_id;
            r          <= '0;
            w          <= '0;
            n          <= '0;
            sweep      <= 1'b1;
            rd_addr    <= (cmd.command == CMD_SCHEDULE) ? cnt_dec[AW-1:0] : '0;
            case (cmd.command)
              CMD_SCHEDULE: begin
                if (full) begin
                  rslt  <= '{status: ST_FULL, ev_id: 32'd0, fired_handle: 16'd0,
                             last: 1'b1};
                  state <= S_EMIT;
                end else begin
                  pos <= count;
                  if (count == '0) begin
                    state <= S_SINS;
                  end else begin
                    state <= S_SRD;
                  end
                end
              end
              CMD_CANCEL: begin
                if (count == '0) begin
                  rslt  <= '{status: ST_NOT_FOUND, ev_id: cmd.target_id,
                             fired_handle: 16'd0, last: 1'b1};
                  state <= S_EMIT;
                end else begin
                  state <= S_CRD;
                end
              end
              CMD_TICK: begin
                cur_time <= cur_time + 32'd1;
                if (count == '0) begin
                  rslt  <= '{status: ST_IDLE, ev_id: 32'd0, fired_handle: 16'd0,
                             last: 1'b1};
                  state <= S_EMIT;
                end else begin
                  state <= S_TRD;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_SRD: state <= S_SCHK;
        S_SCHK: begin
          if (later(rdata.deadline, new_dl)) begin
            pos <= pos_dec;
            if (pos_dec == '0) begin
              state <= S_SINS;
            end else begin
              rd_addr <= pos_dec2[AW-1:0];
              state   <= S_SRD;
            end
          end else begin
            state <= S_SINS;
          end
        end
        S_SINS: begin
          count   <= count + 1'b1;
          rslt    <= '{status: ST_SCHEDULED, ev_id: next_id, fired_handle: 16'd0,
                       last: 1'b1};
          next_id <= next_id + 32'd1;
          state   <= S_EMIT;
        end
        S_CRD: state <= S_CCHK;
        S_CCHK: begin
          if (rdata.id == target) begin
            rslt  <= '{status: ST_CANCELLED, ev_id: target, fired_handle: 16'd0,
                       last: 1'b1};
            state <= S_EMIT;
          end else if (r_inc < count) begin
            r       <= r_inc;
            rd_addr <= r_inc[AW-1:0];
            state   <= S_CRD;
          end else begin
            rslt  <= '{status: ST_NOT_FOUND, ev_id: target, fired_handle: 16'd0,
                       last: 1'b1};
            state <= S_EMIT;
          end
        end
        S_TRD: state <= S_TCHK;
        S_TCHK: begin
          // a fired event waits while the previous one cannot be handed out
          if (!fire || !pend_valid || can_push) begin
            if (fire) begin
              if (pend_valid) begin
                out <= pend;
              end
              pend       <= '{status: ST_FIRED, ev_id: rdata.id,
                              fired_handle: rdata.handle, last: 1'b0};
              pend_valid <= 1'b1;
              n          <= n + 5'd1;
            end else if (copy) begin
              sweep <= 1'b0;
              w     <= w + 1'b1;
            end
            r <= r_inc;
            if (r_inc < count) begin
              rd_addr <= r_inc[AW-1:0];
              state   <= S_TRD;
            end else begin
              state <= S_TEND;
            end
          end
        end
        S_TEND: begin
          count      <= w;
          pend_valid <= 1'b0;
          if (pend_valid) begin
            rslt <= '{status: pend.status, ev_id: pend.ev_id,
                      fired_handle: pend.fired_handle, last: 1'b1};
          end else begin
            rslt <= '{status: ST_IDLE, ev_id: 32'd0, fired_handle: 16'd0, last: 1'b1};
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (can_push) begin
            out   <= rslt;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTHC)
    else $error("queue count above depth");

  a_pend_in_tick: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (state == S_TRD || state == S_TCHK || state == S_TEND))
    else $error("pending fired item outside a tick");

  a_id_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_SINS) |=> (next_id == $past(next_id) + 32'd1))
    else $error("id not advanced on insert");

  a_write_states: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_SCHK || state == S_SINS || state == S_CCHK ||
                state == S_TCHK))
    else $error("RAM write outside a walk");

  a_emit_space: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && !can_push) |=> (state == S_EMIT))
    else $error("result left before output had room");

endmodule

>>> verif/tb.sv
module tb;
  import teq_pkg::*;

  localparam int DEPTH = 16;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [4:0] cfg_wdata = 5'd0;

  teq_cmd_if cmd ();
  teq_res_if rsp ();

  timer_event_queue #(.QUEUE_DEPTH(DEPTH)) DUT (
    .clk(clk), .rst(rst), .cmd(cmd.sink), .rsp(rsp.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // one command item
  typedef struct {
    logic [1:0]  command;
    logic [19:0] interval;
    logic [15:0] handle;
    logic [31:0] target_id;
  } cmd_item_t;

  // directed row: command plus optional typed-in answer
  typedef struct {
    cmd_item_t   c;
    bit          typed;
    logic [2:0]  status;
    logic [31:0] ev_id;
  } row_t;

  // shadow of the queue
  entry_t      shadow_q[$];
  logic [31:0] shadow_next_id;
  logic [31:0] shadow_now;
  logic [4:0]  shadow_cap;

  result_t     expected_results[$];
  int          errors = 0;
  bit          hold_rsp = 1'b0;
  int          rx_wait = 0;
  logic [31:0] recent_ids[$];

  task automatic report(input string what, input result_t got, input result_t want);
    $display("mismatch %s: got st=%0d id=%h h=%h l=%b want st=%0d id=%h h=%h l=%b",
             what, got.status, got.ev_id, got.fired_handle, got.last,
             want.status, want.ev_id, want.fired_handle, want.last);
    errors++;
  endtask

  function automatic bool_after(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return (d != 0) && (d < 32'h8000_0000);
  endfunction

  function automatic result_t mk(input logic [2:0] st, input logic [31:0] id,
                                 input logic [15:0] h);
    result_t r;
    r.status = st; r.ev_id = id; r.fired_handle = h; r.last = 1'b0;
    return r;
  endfunction

  // apply one command to the shadow queue, queue its answers
  task automatic predict_queue(input cmd_item_t c);
    result_t outs[$];
    int eff, pos, n;
    logic [31:0] dl;
    entry_t e, kept[$];
    bit sweeping, hit;
    case (c.command)
      CMD_SCHEDULE: begin
        eff = (shadow_cap < 1) ? 1 : (shadow_cap > DEPTH) ? DEPTH : shadow_cap;
        if (shadow_q.size() >= eff) begin
          outs.insert(outs.size(), mk(ST_FULL, 0, 0));
        end else begin
          dl = shadow_now + c.interval;
          pos = shadow_q.size();
          while (pos > 0 && bool_after(shadow_q[pos-1].deadline, dl)) pos--;
          e.deadline = dl; e.id = shadow_next_id; e.handle = c.handle;
          e.cancelled = 1'b0;
          shadow_q.insert(pos, e);
          outs.insert(outs.size(), mk(ST_SCHEDULED, shadow_next_id, 0));
          recent_ids.insert(recent_ids.size(), shadow_next_id);
          if (recent_ids.size() > 24) void'(recent_ids.pop_front());
          shadow_next_id++;
        end
      end
      CMD_CANCEL: begin
        hit = 1'b0;
        foreach (shadow_q[i]) begin
          if (!hit && shadow_q[i].id == c.target_id) begin
            shadow_q[i].cancelled = 1'b1;
            hit = 1'b1;
          end
        end
        outs.insert(outs.size(), mk(hit ? ST_CANCELLED : ST_NOT_FOUND, c.target_id, 0));
      end
      CMD_TICK: begin
        shadow_now++;
        sweeping = 1'b1;
        n = 0;
        foreach (shadow_q[i]) begin
          if (sweeping && shadow_q[i].cancelled) continue;
          if (sweeping && !bool_after(shadow_q[i].deadline, shadow_now) && n < MAX_FIRE) begin
            outs.insert(outs.size(), mk(ST_FIRED, shadow_q[i].id, shadow_q[i].handle));
            n++;
            continue;
          end
          sweeping = 1'b0;
          kept.insert(kept.size(), shadow_q[i]);
        end
        shadow_q = kept;
        if (n == 0) outs.insert(outs.size(), mk(ST_IDLE, 0, 0));
      end
      default: ;
    endcase
    if (outs.size() > 0) outs[outs.size()-1].last = 1'b1;
    foreach (outs[i]) expected_results.insert(expected_results.size(), outs[i]);
  endtask

  // drive one item with a random lead-in gap; valid stays up across a zero gap
  task automatic send_item(input cmd_item_t c);
    int gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd.valid     <= 1'b1;
    cmd.command   <= c.command;
    cmd.interval  <= c.interval;
    cmd.handle    <= c.handle;
    cmd.target_id <= c.target_id;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    predict_queue(c);
  endtask

  task automatic wait_drained();
    cmd.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [4:0] v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_cap = v;
    @(posedge clk);
  endtask

  function automatic cmd_item_t make_cmd(input logic [1:0] op, input logic [19:0] iv,
                                         input logic [15:0] h, input logic [31:0] t);
    cmd_item_t c;
    c.command = op; c.interval = iv; c.handle = h; c.target_id = t;
    return c;
  endfunction

  function automatic cmd_item_t random_cmd();
    cmd_item_t c;
    int p;
    p = $urandom_range(0, 99);
    c.interval = ($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($urandom_range(0, 6));
    c.handle = 16'($urandom);
    c.target_id = $urandom;
    if (p < 40) c.command = CMD_SCHEDULE;
    else if (p < 55) begin
      c.command = CMD_CANCEL;
      if (recent_ids.size() > 0 && $urandom_range(0, 3) != 0)
        c.target_id = recent_ids[$urandom_range(0, recent_ids.size()-1)];
    end
    else if (p < 97) c.command = CMD_TICK;
    else c.command = 2'd3;
    return c;
  endfunction

  // result checker; the receiver waits a drawn number of cycles per item
  always @(posedge clk) begin
    result_t got, want;
    if (rst) begin
      rsp.ready <= 1'b0;
      rx_wait = $urandom_range(0, 9);
    end else begin
      if (rsp.valid && rsp.ready) begin
        got.status = rsp.status; got.ev_id = rsp.ev_id;
        got.fired_handle = rsp.fired_handle; got.last = rsp.last;
        if (expected_results.size() == 0) begin
          report("unexpected", got, got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) report("field", got, want);
        end
        rx_wait = $urandom_range(0, 9);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      rsp.ready <= !hold_rsp && (rx_wait == 0);
    end
  end

  // directed rows: a few answers typed in, rest from the shadow queue
  row_t rows[$];
  task automatic add_row(input cmd_item_t c, input bit typed, input logic [2:0] st,
                         input logic [31:0] id);
    row_t r;
    r.c = c; r.typed = typed; r.status = st; r.ev_id = id;
    rows.insert(rows.size(), r);
  endtask

  initial begin
    cmd_item_t c;
    result_t want;
    cmd.valid = 1'b0; cmd.command = CMD_TICK; cmd.interval = 0; cmd.handle = 0;
    cmd.target_id = 0;
    shadow_next_id = 0; shadow_now = 0; shadow_cap = 5'd16;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    add_row(make_cmd(CMD_TICK, 0, 0, 0), 1, ST_IDLE, 0);
    add_row(make_cmd(CMD_CANCEL, 0, 0, 32'hFFFF_FFFF), 1, ST_NOT_FOUND, 32'hFFFF_FFFF);
    add_row(make_cmd(CMD_SCHEDULE, 20'd0, 16'hFFFF, 0), 1, ST_SCHEDULED, 0);
    add_row(make_cmd(CMD_SCHEDULE, 20'hFFFFF, 16'h0000, 0), 1, ST_SCHEDULED, 1);
    add_row(make_cmd(CMD_SCHEDULE, 20'd1, 16'hA5A5, 0), 1, ST_SCHEDULED, 2);
    add_row(make_cmd(CMD_SCHEDULE, 20'd1, 16'h5A5A, 0), 1, ST_SCHEDULED, 3);
    add_row(make_cmd(CMD_CANCEL, 0, 0, 32'd3), 1, ST_CANCELLED, 3);
    add_row(make_cmd(CMD_CANCEL, 0, 0, 32'd3), 1, ST_CANCELLED, 3);
    add_row(make_cmd(2'd3, 20'hFFFFF, 16'hFFFF, 32'hFFFF_FFFF), 0, 0, 0);
    add_row(make_cmd(CMD_TICK, 0, 0, 0), 0, 0, 0);
    add_row(make_cmd(CMD_TICK, 0, 0, 0), 0, 0, 0);
    add_row(make_cmd(CMD_CANCEL, 0, 0, 32'd1), 1, ST_CANCELLED, 1);
    add_row(make_cmd(CMD_TICK, 0, 0, 0), 0, 0, 0);
    foreach (rows[i]) begin
      send_item(rows[i].c);
      // typed rows give one result: it is the newest one predicted
      if (rows[i].typed) begin
        want = expected_results[$];
        if (want.status !== rows[i].status || want.ev_id !== rows[i].ev_id)
          report("table", want, mk(rows[i].status, rows[i].ev_id, 0));
      end
    end

    // capacity extremes: 0 acts as 1, 31 acts as full depth
    set_capacity(5'd0);
    send_item(make_cmd(CMD_SCHEDULE, 20'd2, 16'h1234, 0));
    send_item(make_cmd(CMD_SCHEDULE, 20'd2, 16'h4321, 0));
    repeat (3) send_item(make_cmd(CMD_TICK, 0, 0, 0));
    set_capacity(5'd31);
    // seventeen same-deadline events: full on the last, tie order, fire burst
    for (int i = 0; i < 17; i++) send_item(make_cmd(CMD_SCHEDULE, 20'd1, 16'(i), 0));
    send_item(make_cmd(CMD_TICK, 0, 0, 0));

    // random phases across several capacities
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_capacity(5'd16);
        1: set_capacity(5'd1);
        2: set_capacity(5'd5);
        default: set_capacity(5'd16);
      endcase
      for (int i = 0; i < 75; i++) begin
        if (ph == 2 && i == 10) begin
          // receiver holds off while the sender keeps offering
          fork
            begin
              hold_rsp = 1'b1;
              repeat (300) @(posedge clk);
              hold_rsp = 1'b0;
            end
          join_none
        end
        if (ph == 3 && i == 30) wait_drained();
        c = random_cmd();
        send_item(c);
      end
    end
    wait_drained();
    if (errors == 0) begin
      $display("[timer_event_queue] OK");
    end else begin
      $display("[timer_event_queue] ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #4000000;
    $display("[timer_event_queue] ERROR");
    $finish;
  end

endmodule

>>> sim.f
design/teq_pkg.sv
design/teq_cmd_if.sv
design/teq_res_if.sv
design/teq_ram.sv
design/timer_event_queue.sv
verif/tb.sv
